// ===== sv/dsjq_pkg.sv =====
// ----------------------------------------------------------------------------
// dsjq_pkg: shared types and constants for the deadline sorted job queue
// Sizes, operation and status codes, and the records passed along the cells.
// ----------------------------------------------------------------------------
package dsjq_pkg;

  localparam int CAPACITY  = 32;
  localparam int ID_BITS   = 8;
  localparam int TIME_BITS = 32;

  // occupancy count, able to hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // stream widths: fields packed from bit 0, padded to whole bytes
  localparam int IN_FIELDS_W  = 2 + ID_BITS + 2 * TIME_BITS;
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + ID_BITS;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CHECK  = 2'd1,
    OP_EXEC   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_DONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // what every cell does on the update cycle
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_POP    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_MOVE   = 3'd4,
    CMD_SET    = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    logic signed [TIME_BITS-1:0] key;
    logic [ID_BITS-1:0]          id;
  } data_t;

  typedef struct packed {
    logic      en;
    cmd_kind_t kind;
    data_t     item;
  } cmd_t;

  // prefix flags rippling from the head toward the tail
  typedef struct packed {
    logic mp;   // at or after the first id match
    logic ins;  // at or after the insertion point of an add
    logic sq;   // at or after the reinsertion point of a move
    logic fm;   // this cell holds the first id match
  } link_t;

  typedef struct packed {
    logic lt;   // stored key below the compare value, entry valid
    logic mv;   // previous cell is the first match and this key is below the new key
  } cell_stat_t;

endpackage

// ===== sv/dsjq_cell.sv =====
// ----------------------------------------------------------------------------
// dsjq_cell: one queue slot
// Holds one key and id, compares them against the incoming transaction and
// shifts data with its neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module dsjq_cell (
  input  logic                               clk,
  input  logic                               load,
  input  logic signed [dsjq_pkg::TIME_BITS-1:0] cmp_key,
  input  logic [dsjq_pkg::ID_BITS-1:0]       cmp_id,
  input  logic                               occ,
  input  dsjq_pkg::cmd_t                     cmd,
  input  dsjq_pkg::link_t                    link_in,
  output dsjq_pkg::link_t                    link_out,
  input  logic                               sq_right,
  input  dsjq_pkg::data_t                    left_data,
  input  dsjq_pkg::data_t                    right_data,
  output dsjq_pkg::data_t                    data,
  output dsjq_pkg::cell_stat_t               stat
);
  import dsjq_pkg::*;

  data_t data_next;
  logic  f_gt;
  logic  f_lt;
  logic  f_match;
  logic  f_vld;
  logic  mp;
  logic  ins;
  logic  stop;
  logic  sq;

  // capture compare flags when a transaction is accepted
  always_ff @(posedge clk) begin
    if (load) begin
      f_vld   <= occ;
      f_gt    <= occ && (cmp_key < data.key);
      f_lt    <= occ && (data.key < cmp_key);
      f_match <= occ && (cmp_id == data.id);
    end
  end

  // ripple the prefix flags
  always_comb begin
    mp   = link_in.mp | f_match;
    ins  = link_in.ins | f_gt | !f_vld;
    stop = link_in.mp & !f_lt;
    sq   = link_in.sq | stop;
    link_out.mp  = mp;
    link_out.ins = ins;
    link_out.sq  = sq;
    link_out.fm  = mp & !link_in.mp;
    stat.lt = f_lt;
    stat.mv = link_in.fm & f_lt;
  end

  // pick the new slot contents
  always_comb begin
    data_next = data;
    if (cmd.en) begin
      unique case (cmd.kind)
        CMD_HOLD: begin
          data_next = data;
        end
        CMD_ADD: begin
          if (ins) data_next = link_in.ins ? left_data : cmd.item;
        end
        CMD_POP: begin
          data_next = right_data;
        end
        CMD_REMOVE: begin
          if (mp) data_next = right_data;
        end
        CMD_MOVE: begin
          if (mp && !sq) data_next = sq_right ? cmd.item : right_data;
        end
        CMD_SET: begin
          if (mp && !link_in.mp) data_next.key = cmd.item.key;
        end
        default: begin
          data_next = data;
        end
      endcase
    end
  end

  // hold the slot
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sv/deadline_sorted_job_queue.sv =====
// The transaction and compare flags are registered on accept, the result on the
// update. Each item gets a compare step in which every cell flags itself, then
// an update step in which the cell row shifts at once; a new item is taken after.
// The update waits while the output register holds an untaken result.
// Reset: clears the entry count, busy flag and output valid; slot contents
// are left as they are and only slots below the count are ever used.
// ----------------------------------------------------------------------------
// deadline_sorted_job_queue: job queue kept in deadline order
// Row of compare-and-shift cells with a control unit that turns each
// operation into one broadcast command and one result.
// ----------------------------------------------------------------------------
module deadline_sorted_job_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // op[1:0], job_id, start_limit, now_time, zero pad
  input  logic [dsjq_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], result_id, zero pad
  output logic [dsjq_pkg::OUT_W-1:0]  m_tdata
);
  import dsjq_pkg::*;

  localparam int ID_LO  = 2;
  localparam int KEY_LO = ID_LO + ID_BITS;
  localparam int NOW_LO = KEY_LO + TIME_BITS;

  logic                        busy;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  op_t                         op_q;
  data_t                       item;
  status_t                     status;
  status_t                     status_next;
  logic [ID_BITS-1:0]          result_id;
  logic [ID_BITS-1:0]          result_id_next;
  cmd_kind_t                   kind;
  cmd_t                        cmd;
  logic                        load;
  logic                        fire;
  op_t                         in_op;
  logic signed [TIME_BITS-1:0] in_key;
  logic signed [TIME_BITS-1:0] in_now;
  logic signed [TIME_BITS-1:0] cmp_key;
  logic [ID_BITS-1:0]          in_id;
  logic [CAPACITY-1:0]         occ;
  logic [CAPACITY-1:0]         mv_vec;
  logic                        found;
  logic                        move;
  data_t                       cell_data [CAPACITY];
  cell_stat_t                  stats [CAPACITY];
  link_t                       chain [CAPACITY+1];

  // unpack the input transaction
  assign in_op   = op_t'(s_tdata[1:0]);
  assign in_id   = s_tdata[KEY_LO-1:ID_LO];
  assign in_key  = s_tdata[NOW_LO-1:KEY_LO];
  assign in_now  = s_tdata[NOW_LO+TIME_BITS-1:NOW_LO];
  assign cmp_key = (in_op == OP_CHECK) ? in_now : in_key;

  assign s_tready = !busy;
  assign load     = s_tvalid && s_tready;
  assign fire     = busy && (!m_tvalid || m_tready);

  // cell row
  assign chain[0] = '0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  sq_right;
    data_t left_data;
    data_t right_data;

    assign occ[i] = CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = '0;
      assign sq_right   = 1'b1;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign sq_right   = chain[i+2].sq;
    end

    dsjq_cell u_cell (
      .clk        (clk),
      .load       (load),
      .cmp_key    (cmp_key),
      .cmp_id     (in_id),
      .occ        (occ[i]),
      .cmd        (cmd),
      .link_in    (chain[i]),
      .link_out   (chain[i+1]),
      .sq_right   (sq_right),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .stat       (stats[i])
    );

    assign mv_vec[i] = stats[i].mv;
  end

  assign found = chain[CAPACITY].mp;
  assign move  = |mv_vec;

  // decode the held operation into a cell command and a result
  always_comb begin
    kind           = CMD_HOLD;
    count_next     = count;
    status_next    = ST_NONE;
    result_id_next = '0;
    unique case (op_q)
      OP_ADD: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          kind       = CMD_ADD;
          count_next = count + CNT_W'(1);
        end
      end
      OP_CHECK: begin
        if (stats[0].lt) begin
          kind           = CMD_POP;
          count_next     = count - CNT_W'(1);
          status_next    = ST_DONE;
          result_id_next = cell_data[0].id;
        end
      end
      OP_EXEC: begin
        if (found) begin
          kind           = move ? CMD_MOVE : CMD_SET;
          status_next    = ST_DONE;
          result_id_next = item.id;
        end
      end
      OP_FINISH: begin
        if (found) begin
          kind           = CMD_REMOVE;
          count_next     = count - CNT_W'(1);
          status_next    = ST_DONE;
          result_id_next = item.id;
        end
      end
      default: begin
        kind = CMD_HOLD;
      end
    endcase
  end

  assign cmd.en   = fire;
  assign cmd.kind = kind;
  assign cmd.item = item;

  // hold the accepted transaction
  always_ff @(posedge clk) begin
    if (load) begin
      op_q     <= in_op;
      item.id  <= in_id;
      item.key <= in_key;
    end
  end

  // control: busy flag, count, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status    <= status_next;
      result_id <= result_id_next;
    end
  end

  assign m_tdata = {{(OUT_W - OUT_FIELDS_W){1'b0}}, result_id, status};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("entry count changed without an update");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (fire && status_next == ST_FULL) |-> (op_q == OP_ADD && count == CNT_W'(CAPACITY)))
    else $error("full rejection without a full queue");

  a_add_no_id: assert property (@(posedge clk) disable iff (rst)
    (fire && op_q == OP_ADD) |-> (status_next != ST_DONE && result_id_next == '0))
    else $error("add returned a job");

endmodule
